// ----- rtl/core/touch_two_cluster_calibrator_unit_defines.svh -----
// Assertion macros shared by the touch calibrator RTL.
`ifndef TOUCH_TWO_CLUSTER_CALIBRATOR_UNIT_DEFINES_SVH
`define TOUCH_TWO_CLUSTER_CALIBRATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define TCC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define TCC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);
`else
`define TCC_ASSERT(label, cond, msg)
`define TCC_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

// ----- rtl/core/tcc_pkg.sv -----
// Package of constants and types for the touch calibrator.
package tcc_pkg;

  localparam int INIT_COUNT = 10;
  localparam int FRAC_BITS  = 8;

  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int MEAN_W   = 18;
  localparam int CFG_IDX_W = 2;

  // Calibration countdown and raw sum
  localparam int INIT_W = $clog2(INIT_COUNT + 1);
  localparam int SUM_W  = $clog2(INIT_COUNT * (2 ** SAMPLE_W - 1) + 1);

  // Fixed-point level and mean widths
  localparam int LVL_W  = SAMPLE_W + FRAC_BITS;
  localparam int HIGH_W = LVL_W + 2;

  // Exact division of the shifted sum by INIT_COUNT via a rounded-up reciprocal
  localparam int DIVN_W   = SUM_W + FRAC_BITS;
  localparam int RECIP_SH = DIVN_W + $clog2(INIT_COUNT);
  localparam int RECIP_W  = RECIP_SH - $clog2(INIT_COUNT) + 1;
  localparam int PROD_W   = DIVN_W + RECIP_W;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << RECIP_SH) + 64'(INIT_COUNT - 1)) / 64'(INIT_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

  // Mean tracking blend
  localparam int BLEND_W = HIGH_W + GAIN_W + 2;
  localparam logic [GAIN_W:0] GAIN_ONE = (GAIN_W + 1)'(1) << GAIN_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = CFG_IDX_W'(2);

  // Configuration reset values
  localparam logic [CFG_W-1:0] THRESHOLD_RST = CFG_W'(500);
  localparam logic [CFG_W-1:0] CEILING_RST   = CFG_W'(10000);
  localparam logic [CFG_W-1:0] GAIN_RST      = CFG_W'(1311);

  typedef struct packed {
    logic [CFG_W-1:0]  threshold;
    logic [CFG_W-1:0]  ceiling;
    logic [GAIN_W-1:0] gain;
  } tcc_cfg_t;

  typedef struct packed {
    logic                calibrating;
    logic                touched;
    logic [SAMPLE_W-1:0] level;
    logic [MEAN_W-1:0]   low_mean;
    logic [MEAN_W-1:0]   high_mean;
  } tcc_res_t;

endpackage

// ----- rtl/core/tcc_core.sv -----
// Calibration and two-cluster tracking state with its single-pass update.
`include "touch_two_cluster_calibrator_unit_defines.svh"

module tcc_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [tcc_pkg::SAMPLE_W-1:0]     sample_i,
  input  tcc_pkg::tcc_cfg_t                cfg_i,
  output tcc_pkg::tcc_res_t                res_o
);

  localparam int LW = tcc_pkg::LVL_W;
  localparam int HW = tcc_pkg::HIGH_W;
  localparam int FB = tcc_pkg::FRAC_BITS;

  logic [tcc_pkg::INIT_W-1:0] init_left_q, init_left_d;
  logic [tcc_pkg::SUM_W-1:0]  sum_q, sum_d, sum_nx;
  logic [LW-1:0]              low_q, low_d, low_n;
  logic [HW-1:0]              high_q, high_d, high_n;
  logic [LW-1:0]              level_q, level_d;
  logic                       cluster_q, cluster_d, cluster_t;

  logic                        calib, last;
  logic [tcc_pkg::DIVN_W-1:0]  div_n;
  logic [tcc_pkg::PROD_W-1:0]  div_prod;
  logic [LW-1:0]               div_q;
  logic [HW-1:0]               high_fin;

  logic [LW-1:0]                 thr_fx, ceil_fx;
  logic [LW:0]                   lvl_sum;
  logic [LW-1:0]                 lvl_n;
  logic                          below_ceil, low_win, high_win, to_low, to_high;
  logic [HW-1:0]                 mean_sel;
  logic [tcc_pkg::GAIN_W:0]      gain_inv;
  logic [tcc_pkg::BLEND_W-1:0]   blend_sum;
  logic [HW-1:0]                 blend;

  assign calib = (init_left_q != '0);
  assign last  = (init_left_q == tcc_pkg::INIT_W'(1));

  // Calibration: sum, then divide by the sample count
  assign sum_nx   = sum_q + tcc_pkg::SUM_W'(sample_i);
  assign div_n    = {sum_nx, {FB{1'b0}}};
  assign div_prod = tcc_pkg::PROD_W'(div_n) * tcc_pkg::PROD_W'(tcc_pkg::RECIP);
  assign div_q    = div_prod[tcc_pkg::RECIP_SH +: LW];

  assign thr_fx   = {cfg_i.threshold, {FB{1'b0}}};
  assign ceil_fx  = {cfg_i.ceiling, {FB{1'b0}}};
  assign high_fin = HW'(div_q) + HW'({thr_fx, 1'b0});

  // Tracking: half-and-half smoothing
  assign lvl_sum = {1'b0, level_q} + {1'b0, sample_i, {FB{1'b0}}};
  assign lvl_n   = lvl_sum[LW:1];

  assign below_ceil = (lvl_n < ceil_fx);
  assign low_win  = !cluster_q && below_ceil &&
                    ((HW'(lvl_n) + HW'(thr_fx)) < high_q);
  assign high_win = cluster_q && below_ceil &&
                    ((LW+1)'(lvl_n) > ((LW+1)'(low_q) + (LW+1)'(thr_fx)));

  // One blend unit serves whichever mean belongs to the current cluster
  assign mean_sel  = cluster_q ? high_q : HW'(low_q);
  assign gain_inv  = tcc_pkg::GAIN_ONE - {1'b0, cfg_i.gain};
  assign blend_sum = tcc_pkg::BLEND_W'(mean_sel) * tcc_pkg::BLEND_W'(gain_inv) +
                     tcc_pkg::BLEND_W'(lvl_n) * tcc_pkg::BLEND_W'(cfg_i.gain);
  assign blend     = blend_sum[tcc_pkg::GAIN_W +: HW];

  assign low_n  = low_win  ? blend[LW-1:0] : low_q;
  assign high_n = high_win ? blend : high_q;

  // Reclassify with hysteresis; the high test wins
  assign to_low  = ((LW+1)'(lvl_n) < ((LW+1)'(low_n) + (LW+1)'(thr_fx)));
  assign to_high = ((HW'(lvl_n) + HW'(thr_fx)) > high_n);

  always_comb begin
    if (to_high) begin
      cluster_t = 1'b1;
    end else if (to_low) begin
      cluster_t = 1'b0;
    end else begin
      cluster_t = cluster_q;
    end
  end

  always_comb begin
    init_left_d = init_left_q;
    sum_d       = sum_q;
    low_d       = low_q;
    high_d      = high_q;
    level_d     = level_q;
    cluster_d   = cluster_q;
    if (calib) begin
      init_left_d = init_left_q - tcc_pkg::INIT_W'(1);
      sum_d       = sum_nx;
      if (last) begin
        low_d   = div_q;
        high_d  = high_fin;
        level_d = div_q;
      end
    end else begin
      level_d   = lvl_n;
      low_d     = low_n;
      high_d    = high_n;
      cluster_d = cluster_t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_left_q <= tcc_pkg::INIT_W'(tcc_pkg::INIT_COUNT);
      sum_q       <= '0;
      low_q       <= '0;
      high_q      <= '0;
      level_q     <= '0;
      cluster_q   <= 1'b0;
    end else if (step_i) begin
      init_left_q <= init_left_d;
      sum_q       <= sum_d;
      low_q       <= low_d;
      high_q      <= high_d;
      level_q     <= level_d;
      cluster_q   <= cluster_d;
    end
  end

  // Result of the item being stepped, zeroed while calibration still runs
  always_comb begin
    res_o.calibrating = (init_left_d != '0);
    if (res_o.calibrating) begin
      res_o.touched   = 1'b0;
      res_o.level     = '0;
      res_o.low_mean  = '0;
      res_o.high_mean = '0;
    end else begin
      res_o.touched   = cluster_d;
      res_o.level     = level_d[FB +: tcc_pkg::SAMPLE_W];
      res_o.low_mean  = tcc_pkg::MEAN_W'(low_d[FB +: tcc_pkg::SAMPLE_W]);
      res_o.high_mean = high_d[FB +: tcc_pkg::MEAN_W];
    end
  end

  `TCC_ASSERT_NEXT(a_calib_stays_done, init_left_q == '0, init_left_q == '0, "calibration restarted")
  `TCC_ASSERT(a_means_ordered, (init_left_q != '0) || (high_q >= HW'(low_q)), "high mean below low mean")
  `TCC_ASSERT(a_cluster_idle_in_calib, (init_left_q == '0) || !cluster_q, "cluster set during calibration")

endmodule

// ----- rtl/core/touch_two_cluster_calibrator_unit.sv -----
// Top level of the two-cluster touch calibrator: handshake, registers, result stage.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | in        | in_valid_i / in_stall_o  | sample_i
//  out     | out       | out_valid_o / out_stall_i| calibrating_o touched_o level_o
//          |           |                          | low_mean_o high_mean_o
//  cfg     | in        | cfg_we_i                 | cfg_idx_i cfg_data_i
//
// Throughput is one item per cycle while the output is not stalled; each item moves
// from the input register to the result register, with the whole update (smoothing,
// one blend multiply, reclassification) between them. The calibration divide is a single reciprocal multiply.
// Reset puts the block straight into calibration; there is no clearing pass.
// A held result at the output does not block intake: one more item waits in the
// input register, and only then is in_stall_o raised.
`include "touch_two_cluster_calibrator_unit_defines.svh"

module touch_two_cluster_calibrator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tcc_pkg::SAMPLE_W-1:0]      sample_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              calibrating_o,
  output logic                              touched_o,
  output logic [tcc_pkg::SAMPLE_W-1:0]      level_o,
  output logic [tcc_pkg::MEAN_W-1:0]        low_mean_o,
  output logic [tcc_pkg::MEAN_W-1:0]        high_mean_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tcc_pkg::CFG_W-1:0]         cfg_data_i
);

  tcc_pkg::tcc_cfg_t cfg_q, cfg_d;

  logic                         s1_valid_q, s1_valid_d;
  logic [tcc_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic                         out_valid_q, out_valid_d;
  tcc_pkg::tcc_res_t            out_res_q, core_res;

  logic in_acc, out_free, s1_adv;

  // Configuration decode; unknown indexes drop the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcc_pkg::CFG_THRESHOLD: cfg_d.threshold = cfg_data_i;
        tcc_pkg::CFG_CEILING:   cfg_d.ceiling   = cfg_data_i;
        tcc_pkg::CFG_GAIN:      cfg_d.gain      = cfg_data_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= tcc_pkg::THRESHOLD_RST;
      cfg_q.ceiling   <= tcc_pkg::CEILING_RST;
      cfg_q.gain      <= tcc_pkg::GAIN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Handshake: advance the input register whenever the result stage can take an item
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
    end
    if (s1_adv) begin
      out_res_q <= core_res;
    end
  end

  // State update for the item leaving the input register
  tcc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg_q),
    .res_o    (core_res)
  );

  assign out_valid_o   = out_valid_q;
  assign calibrating_o = out_res_q.calibrating;
  assign touched_o     = out_res_q.touched;
  assign level_o       = out_res_q.level;
  assign low_mean_o    = out_res_q.low_mean;
  assign high_mean_o   = out_res_q.high_mean;

  `TCC_ASSERT(a_stall_only_when_full, !in_stall_o || (s1_valid_q && out_valid_q), "stall with a free slot")
  `TCC_ASSERT_NEXT(a_item_kept, s1_valid_q && !s1_adv, s1_valid_q, "waiting item lost")
  `TCC_ASSERT(a_calib_zeros, !(out_valid_q && calibrating_o) || (!touched_o && level_o == '0 && low_mean_o == '0 && high_mean_o == '0), "nonzero result during calibration")

endmodule
